// ===== hw/rtl/bmp24_pkg.sv =====
package bmp24_pkg;

	// Parse phases of the byte stream
	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_PIXEL  = 3'd2,
		PH_PAD    = 3'd3,
		PH_DRAIN  = 3'd4
	} phase_t;

	// Component position inside one pixel triple
	typedef enum logic [1:0] {
		CP_BLUE  = 2'd0,
		CP_GREEN = 2'd1,
		CP_RED   = 2'd2
	} comp_t;

	typedef enum logic {
		RK_PIXEL  = 1'b0,
		RK_REJECT = 1'b1
	} result_kind_t;

	// APB register map
	localparam int unsigned ADDR_BITS = 3;
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_FILE_LENGTH = 1'b0;

	// Header layout (byte offsets, little endian fields)
	localparam int unsigned HDR_BYTES      = 54;
	localparam int unsigned HDR_LAST       = HDR_BYTES - 1;
	localparam int unsigned HOFS_SIGNATURE = 0;
	localparam int unsigned HOFS_OFFSET    = 10;
	localparam int unsigned HOFS_INFO_SIZE = 14;
	localparam int unsigned HOFS_WIDTH     = 18;
	localparam int unsigned HOFS_HEIGHT    = 22;
	localparam int unsigned HOFS_PLANES    = 26;
	localparam int unsigned HOFS_BPP       = 28;
	localparam int unsigned HOFS_COMPRESS  = 30;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [31:0] BMP_INFO_SIZE = 32'd40;
	localparam logic [15:0] BMP_PLANES    = 16'd1;
	localparam logic [15:0] BMP_BPP       = 16'd24;

	typedef struct packed {
		logic ok;
		logic top_down;
	} hdr_flags_t;

endpackage

// ===== hw/rtl/bmp24_apb_regs.sv =====
module bmp24_apb_regs #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bmp24_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [LENGTH_BITS-1:0]          file_length
);
	import bmp24_pkg::*;

	reg_idx_t                 reg_idx;
	logic [LENGTH_BITS-1:0]   file_length_q;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == REG_FILE_LENGTH) begin
			file_length_q <= pwdata[LENGTH_BITS-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FILE_LENGTH: prdata = 32'(file_length_q);
			default:         prdata = '0;
		endcase
	end

	assign file_length = file_length_q;

endmodule

// ===== hw/rtl/bmp24_hdr_check.sv =====
module bmp24_hdr_check #(
	parameter int unsigned MAX_WIDTH   = 1024,
	parameter int unsigned MAX_HEIGHT  = 1024,
	parameter int unsigned LENGTH_BITS = 24,
	localparam int unsigned WB = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HB = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                      clk,
	input  logic                      capture,
	input  logic [LENGTH_BITS-1:0]    pos,
	input  logic [7:0]                byte_in,
	input  logic [LENGTH_BITS-1:0]    file_length,
	output bmp24_pkg::hdr_flags_t     flags,
	output logic [WB-1:0]             width,
	output logic [HB-1:0]             height,
	output logic [LENGTH_BITS-1:0]    offset
);
	import bmp24_pkg::*;

	localparam int unsigned PAD_W  = WB + 2;
	localparam int unsigned PROD_W = PAD_W + HB;
	localparam int unsigned NEED_W = ((PROD_W > 32) ? PROD_W : 32) + 1;

	logic [15:0]        sig_q, planes_q, bpp_q;
	logic [31:0]        off_q, info_q, w_q, h_q, comp_q;
	logic [31:0]        mag;
	logic [WB-1:0]      w_lo;
	logic [PAD_W-1:0]   padded;
	logic [PROD_W-1:0]  prod_q;
	logic [NEED_W-1:0]  need;
	logic               fmt_ok, w_ok, h_ok, off_ok, len_ok;

	// Only the fields that are checked are kept; other header bytes are dropped
	always_ff @(posedge clk) begin
		if (capture) begin
			for (int i = 0; i < 2; i++) begin
				if (pos == LENGTH_BITS'(HOFS_SIGNATURE + i)) sig_q[8*i +: 8]    <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_PLANES + i))    planes_q[8*i +: 8] <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_BPP + i))       bpp_q[8*i +: 8]    <= byte_in;
			end
			for (int i = 0; i < 4; i++) begin
				if (pos == LENGTH_BITS'(HOFS_OFFSET + i))    off_q[8*i +: 8]  <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_INFO_SIZE + i)) info_q[8*i +: 8] <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_WIDTH + i))     w_q[8*i +: 8]    <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_HEIGHT + i))    h_q[8*i +: 8]    <= byte_in;
				if (pos == LENGTH_BITS'(HOFS_COMPRESS + i))  comp_q[8*i +: 8] <= byte_in;
			end
		end
	end

	assign mag    = h_q[31] ? (~h_q + 32'd1) : h_q;
	assign w_lo   = w_q[WB-1:0];
	// row stride rounded up to 4 bytes; low width bits suffice once width is in range
	assign padded = ((PAD_W'(w_lo) << 1) + PAD_W'(w_lo) + PAD_W'(3)) & ~PAD_W'(3);

	// The fields settle long before the last header byte, so the product
	// is registered well ahead of the check
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(padded) * PROD_W'(mag[HB-1:0]);
	end

	assign fmt_ok = (sig_q == BMP_SIGNATURE) && (info_q == BMP_INFO_SIZE) &&
	                (planes_q == BMP_PLANES) && (bpp_q == BMP_BPP) && (comp_q == '0);
	assign w_ok   = (w_q != '0) && !w_q[31] && (w_q <= 32'(MAX_WIDTH));
	assign h_ok   = (h_q != '0) && (mag <= 32'(MAX_HEIGHT));
	assign off_ok = (off_q >= 32'(HDR_BYTES)) && (off_q <= 32'(file_length));
	assign need   = NEED_W'(off_q) + NEED_W'(prod_q);
	assign len_ok = need <= NEED_W'(file_length);

	assign flags.ok       = fmt_ok && w_ok && h_ok && off_ok && len_ok;
	assign flags.top_down = h_q[31];
	assign width          = w_lo;
	assign height         = mag[HB-1:0];
	assign offset         = off_q[LENGTH_BITS-1:0];

endmodule

// ===== hw/rtl/bmp24_stream_decoder_core.sv =====
// Channel  | Handshake                | Payload
// -------- | ------------------------ | -----------------------------------------------
// in       | in_valid / in_stall      | file_byte
// out      | out_valid / out_stall    | result_kind, pixel_rgb, pixel_row, pixel_column,
//          |                          | last_pixel
// config   | APB psel/penable/pwrite  | paddr, pwdata, prdata (file_length at 0x0)
//
// One byte per cycle while out_stall is low: a request is taken into the input register
// and its result is registered into the output register.
// The header check runs in the cycle of the last header byte.
// Reset clears the parse state, the output valid and file_length.
// While a result waits under out_stall and the input register is empty, one more
// byte is taken into it, then in_stall rises.
module bmp24_stream_decoder_core #(
	parameter int unsigned MAX_WIDTH   = 1024,
	parameter int unsigned MAX_HEIGHT  = 1024,
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bmp24_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      file_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            result_kind,
	output logic [23:0]                     pixel_rgb,
	output logic [9:0]                      pixel_row,
	output logic [9:0]                      pixel_column,
	output logic                            last_pixel
);
	import bmp24_pkg::*;

	localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned PW = LENGTH_BITS + 1;

	logic [LENGTH_BITS-1:0] file_length;
	hdr_flags_t             hflags;
	logic [WB-1:0]          hdr_width;
	logic [HB-1:0]          hdr_height;
	logic [LENGTH_BITS-1:0] hdr_offset;

	// input stage
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance, in_acc, proc;

	// parse state
	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] pos_q, pos_d, offset_q, offset_d;
	logic [WB-1:0]          width_q, width_d;
	logic [HB-1:0]          height_q, height_d;
	logic                   top_q, top_d;
	logic [RW-1:0]          row_q, row_d;
	logic [CW-1:0]          col_q, col_d;
	comp_t                  comp_q, comp_d;
	logic [15:0]            held_q, held_d;
	logic [1:0]             pad_q, pad_d, pad_dec;

	logic [PW-1:0]          pos_p1;
	logic                   at_hdr_last, eof, last_col, last_row;
	logic [HB-1:0]          row_tgt;

	// result
	logic                   emit;
	result_kind_t           kind_d;
	logic [23:0]            rgb_d;
	logic [9:0]             prow_d, pcol_d;
	logic                   plast_d;

	logic                   out_valid_q, kind_q, last_q;
	logic [23:0]            rgb_q;
	logic [9:0]             prow_q, pcol_q;

	bmp24_apb_regs #(.LENGTH_BITS(LENGTH_BITS)) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.file_length (file_length)
	);

	bmp24_hdr_check #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.LENGTH_BITS (LENGTH_BITS)
	) u_hdr (
		.clk         (clk),
		.capture     (proc && file_length != '0 && phase_q == PH_HEADER),
		.pos         (pos_q),
		.byte_in     (byte_s1),
		.file_length (file_length),
		.flags       (hflags),
		.width       (hdr_width),
		.height      (hdr_height),
		.offset      (hdr_offset)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign proc     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= file_byte;
		end
	end

	assign pos_p1      = PW'(pos_q) + PW'(1);
	assign at_hdr_last = pos_q == LENGTH_BITS'(HDR_LAST);
	assign eof         = pos_p1 >= PW'(file_length);
	assign last_col    = (WB + 1)'(col_q) + (WB + 1)'(1) >= (WB + 1)'(width_q);
	assign last_row    = (HB + 1)'(row_q) + (HB + 1)'(1) >= (HB + 1)'(height_q);
	assign row_tgt     = top_q ? HB'(row_q) : height_q - HB'(1) - HB'(row_q);
	assign pad_dec     = (pad_q != 2'd0) ? pad_q - 2'd1 : pad_q;

	// next state
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		offset_d = offset_q;
		width_d  = width_q;
		height_d = height_q;
		top_d    = top_q;
		row_d    = row_q;
		col_d    = col_q;
		comp_d   = comp_q;
		held_d   = held_q;
		pad_d    = pad_q;
		if (proc && file_length != '0) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (at_hdr_last) begin
						if (hflags.ok) begin
							width_d  = hdr_width;
							height_d = hdr_height;
							top_d    = hflags.top_down;
							offset_d = hdr_offset;
							phase_d  = (hdr_offset > LENGTH_BITS'(HDR_BYTES)) ? PH_SKIP
							                                                   : PH_PIXEL;
						end else begin
							phase_d = PH_DRAIN;
						end
					end
				end
				PH_SKIP: begin
					if (pos_p1 >= PW'(offset_q)) begin
						phase_d = PH_PIXEL;
					end
				end
				PH_PIXEL: begin
					unique case (comp_q)
						CP_BLUE: begin
							held_d = {8'h00, byte_s1};
							comp_d = CP_GREEN;
						end
						CP_GREEN: begin
							held_d = {byte_s1, held_q[7:0]};
							comp_d = CP_RED;
						end
						default: begin
							held_d = '0;
							comp_d = CP_BLUE;
							if (!last_col) begin
								col_d = col_q + CW'(1);
							end else if (last_row) begin
								phase_d = PH_DRAIN;
							end else begin
								col_d = '0;
								row_d = row_q + RW'(1);
								// (4 - 3w) mod 4 equals w mod 4
								pad_d = 2'(width_q);
								if (2'(width_q) != 2'd0) begin
									phase_d = PH_PAD;
								end
							end
						end
					endcase
				end
				PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == 2'd0) begin
						phase_d = PH_PIXEL;
					end
				end
				PH_DRAIN: begin
				end
				default: phase_d = PH_HEADER;
			endcase

			// a rejected header drops the image state
			if (phase_q == PH_HEADER && at_hdr_last && !hflags.ok) begin
				width_d  = '0;
				height_d = '0;
				top_d    = 1'b0;
				offset_d = '0;
			end

			if (eof) begin
				pos_d    = '0;
				phase_d  = PH_HEADER;
				width_d  = '0;
				height_d = '0;
				top_d    = 1'b0;
				offset_d = '0;
				row_d    = '0;
				col_d    = '0;
				comp_d   = CP_BLUE;
				held_d   = '0;
				pad_d    = '0;
			end else begin
				pos_d = pos_p1[LENGTH_BITS-1:0];
			end
		end
	end

	// result of the current request
	always_comb begin
		emit    = 1'b0;
		kind_d  = RK_PIXEL;
		rgb_d   = '0;
		prow_d  = '0;
		pcol_d  = '0;
		plast_d = 1'b0;
		if (proc && file_length != '0) begin
			unique case (phase_q)
				PH_HEADER: begin
					// bad header at its last byte, or a file ending inside the header
					if (at_hdr_last ? !hflags.ok : eof) begin
						emit   = 1'b1;
						kind_d = RK_REJECT;
					end
				end
				PH_PIXEL: begin
					if (comp_q == CP_RED) begin
						emit    = 1'b1;
						rgb_d   = {byte_s1, held_q};
						prow_d  = 10'(row_tgt);
						pcol_d  = 10'(col_q);
						plast_d = last_row && last_col;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			offset_q <= '0;
			width_q  <= '0;
			height_q <= '0;
			top_q    <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			comp_q   <= CP_BLUE;
			held_q   <= '0;
			pad_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			offset_q <= offset_d;
			width_q  <= width_d;
			height_q <= height_d;
			top_q    <= top_d;
			row_q    <= row_d;
			col_q    <= col_d;
			comp_q   <= comp_d;
			held_q   <= held_d;
			pad_q    <= pad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= kind_d;
			rgb_q  <= rgb_d;
			prow_q <= prow_d;
			pcol_q <= pcol_d;
			last_q <= plast_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign pixel_rgb    = rgb_q;
	assign pixel_row    = prow_q;
	assign pixel_column = pcol_q;
	assign last_pixel   = last_q;

	// once past the header the position can never sit inside it
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEADER |-> pos_q >= LENGTH_BITS'(HDR_BYTES))
		else $error("parse phase left header before the header was complete");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAD |-> pad_q != 2'd0)
		else $error("padding phase with no padding left");

	assert property (@(posedge clk) disable iff (!arst_n)
		comp_q != CP_BLUE |-> phase_q == PH_PIXEL && comp_q != 2'd3)
		else $error("partial pixel held outside the pixel phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_REJECT |->
			pixel_rgb == '0 && pixel_row == '0 && pixel_column == '0 && !last_pixel)
		else $error("rejected result carries pixel data");

endmodule
